FILE: design/spq_pkg.sv
// spq_pkg: sizes, request and status codes and the controller command word
// for the sorted priority queue; no dependencies
`default_nettype none

package spq_pkg;

  localparam int DEPTH     = 16;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 8;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP_FRONT = 2'd1,
    REQ_SEARCH    = 2'd2,
    REQ_REMOVE_ID = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_HERE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the request word
    logic exec;   // apply the captured request to the cells
  } spq_cmd_t;

endpackage

`default_nettype wire

FILE: design/spq_req_if.sv
// spq_req_if: request channel of the sorted priority queue
// depends on spq_pkg
`default_nettype none

interface spq_req_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [ID_BITS-1:0]   entry_id;
  logic [PRIO_BITS-1:0] entry_priority;

  modport source (output valid, req_type, entry_id, entry_priority, input ready);
  modport sink   (input valid, req_type, entry_id, entry_priority, output ready);
endinterface

`default_nettype wire

FILE: design/spq_rsp_if.sv
// spq_rsp_if: response channel of the sorted priority queue
// depends on spq_pkg
`default_nettype none

interface spq_rsp_if;
  import spq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ID_BITS-1:0]   result_id;
  logic [PRIO_BITS-1:0] result_priority;
  logic [CNT_BITS-1:0]  entry_count;
  logic                 front_valid;
  logic [ID_BITS-1:0]   front_id;
  logic [PRIO_BITS-1:0] front_priority;

  modport source (output valid, status, result_id, result_priority, entry_count,
                  front_valid, front_id, front_priority, input ready);
  modport sink   (input valid, status, result_id, result_priority, entry_count,
                  front_valid, front_id, front_priority, output ready);
endinterface

`default_nettype wire

FILE: design/sorted_priority_queue.sv
// sorted_priority_queue: top level, joins sequencer and datapath
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ctrl, spq_datapath
//
// Usage:
//   req carries one request word: req_type (insert, remove front, search by
//   id, remove by id), entry_id and entry_priority. rsp returns one word per
//   request: status, the removed or found entry, the count and the front
//   entry as they stand after the request.
//   Up to 16 entries sit in a row of cells kept in descending priority
//   order; an insert lands behind every entry of equal or higher priority.
//   All cells compare against the request in parallel and shift together in
//   the cell update step, so the response word turns valid once the update
//   is done (take, update, respond). The sequencer handles one request at a
//   time, so no new request is taken before the response word of the last
//   one is accepted.
//   When the receiver stalls, the response word is held and no new request
//   is taken until it is accepted.
//   Synchronous reset empties the queue; cell contents are not cleared, an
//   empty queue reports a zero front entry.
`default_nettype none

module sorted_priority_queue (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req_type        (req.req_type),
    .entry_id        (req.entry_id),
    .entry_priority  (req.entry_priority),
    .status          (rsp.status),
    .result_id       (rsp.result_id),
    .result_priority (rsp.result_priority),
    .entry_count     (rsp.entry_count),
    .front_valid     (rsp.front_valid),
    .front_id        (rsp.front_id),
    .front_priority  (rsp.front_priority)
  );

endmodule

`default_nettype wire

FILE: design/spq_ctrl.sv
// spq_ctrl: request sequencer of the sorted priority queue
// depends on spq_pkg
`default_nettype none

module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output spq_pkg::spq_cmd_t      cmd
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_RESP;
      S_RESP: if (rsp_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshakes and commands
  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);
  assign cmd.load  = (state == S_IDLE) && req_valid;
  assign cmd.exec  = (state == S_EXEC);

endmodule

`default_nettype wire

FILE: design/spq_datapath.sv
// spq_datapath: sorted cell array, parallel compare and result register
// depends on spq_pkg
`default_nettype none

module spq_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire spq_pkg::spq_cmd_t              cmd,
  input  wire logic [1:0]                     req_type,
  input  wire logic [spq_pkg::ID_BITS-1:0]    entry_id,
  input  wire logic [spq_pkg::PRIO_BITS-1:0]  entry_priority,
  output logic [1:0]                          status,
  output logic [spq_pkg::ID_BITS-1:0]         result_id,
  output logic [spq_pkg::PRIO_BITS-1:0]       result_priority,
  output logic [spq_pkg::CNT_BITS-1:0]        entry_count,
  output logic                                front_valid,
  output logic [spq_pkg::ID_BITS-1:0]         front_id,
  output logic [spq_pkg::PRIO_BITS-1:0]       front_priority
);
  import spq_pkg::*;

  // captured request word
  req_type_t            op;
  logic [ID_BITS-1:0]   op_id;
  logic [PRIO_BITS-1:0] op_prio;

  // cells, front at index 0
  logic [ID_BITS-1:0]   slot_id   [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio [DEPTH];
  logic [CNT_BITS-1:0]  count;

  logic [DEPTH-1:0]     live;
  logic [DEPTH-1:0]     ahead;    // entry stays ahead of an insert
  logic [DEPTH-1:0]     hit;
  logic [DEPTH-1:0]     seen;     // a hit lies in front of this cell
  logic [DEPTH-1:0]     first;
  logic                 found;
  logic [ID_BITS-1:0]   hit_id;
  logic [PRIO_BITS-1:0] hit_prio;
  logic                 full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= req_type_t'(req_type);
      op_id   <= entry_id;
      op_prio <= entry_priority;
    end
  end

  // per-cell compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i]  = CNT_BITS'(i) < count;
      ahead[i] = live[i] && (slot_prio[i] >= op_prio);
      hit[i]   = live[i] && (slot_id[i] == op_id);
    end
  end

  // first match front to back
  always_comb begin
    seen[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      seen[i] = seen[i-1] | hit[i-1];
    end
    first    = hit & ~seen;
    found    = |hit;
    hit_id   = '0;
    hit_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        hit_id   = slot_id[i];
        hit_prio = slot_prio[i];
      end
    end
  end

  assign full = (count == CNT_BITS'(DEPTH));

  // cell updates
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (op) inside
        REQ_INSERT: begin
          if (!full) begin
            // front cell takes the new entry unless it stays ahead
            if (!ahead[0]) begin
              slot_id[0]   <= op_id;
              slot_prio[0] <= op_prio;
            end
            for (int i = 1; i < DEPTH; i++) begin
              if (!ahead[i]) begin
                if (ahead[i-1]) begin
                  slot_id[i]   <= op_id;
                  slot_prio[i] <= op_prio;
                end else begin
                  slot_id[i]   <= slot_id[i-1];
                  slot_prio[i] <= slot_prio[i-1];
                end
              end
            end
          end
        end
        REQ_POP_FRONT: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            slot_id[i]   <= slot_id[i+1];
            slot_prio[i] <= slot_prio[i+1];
          end
        end
        REQ_REMOVE_ID: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (seen[i] || hit[i]) begin
              slot_id[i]   <= slot_id[i+1];
              slot_prio[i] <= slot_prio[i+1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      unique case (op) inside
        REQ_INSERT:    if (!full) count <= count + CNT_BITS'(1);
        REQ_POP_FRONT: if (count != '0) count <= count - CNT_BITS'(1);
        REQ_REMOVE_ID: if (found) count <= count - CNT_BITS'(1);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_id       <= '0;
      result_priority <= '0;
      status          <= ST_OK;
      unique case (op) inside
        REQ_INSERT: begin
          if (full) status <= ST_FULL;
        end
        REQ_POP_FRONT: begin
          if (count == '0) begin
            status <= ST_NOT_HERE;
          end else begin
            result_id       <= slot_id[0];
            result_priority <= slot_prio[0];
          end
        end
        REQ_SEARCH, REQ_REMOVE_ID: begin
          if (!found) begin
            status <= ST_NOT_HERE;
          end else begin
            result_id       <= hit_id;
            result_priority <= hit_prio;
          end
        end
        default: ;
      endcase
    end
  end

  // front entry straight from cell 0
  assign entry_count    = count;
  assign front_valid    = (count != '0);
  assign front_id       = front_valid ? slot_id[0]   : '0;
  assign front_priority = front_valid ? slot_prio[0] : '0;

endmodule

`default_nettype wire

FILE: bench/spq_checker.sv
// spq_checker: watches the request and response channels of the sorted priority queue,
// keeps its own sorted list of entries and compares every response word field by field
// depends on spq_pkg
`default_nettype none

module spq_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  input  wire logic                          req_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [spq_pkg::ID_BITS-1:0]   entry_id,
  input  wire logic [spq_pkg::PRIO_BITS-1:0] entry_priority,
  input  wire logic                          rsp_valid,
  input  wire logic                          rsp_ready,
  input  wire logic [1:0]                    status,
  input  wire logic [spq_pkg::ID_BITS-1:0]   result_id,
  input  wire logic [spq_pkg::PRIO_BITS-1:0] result_priority,
  input  wire logic [spq_pkg::CNT_BITS-1:0]  entry_count,
  input  wire logic                          front_valid,
  input  wire logic [spq_pkg::ID_BITS-1:0]   front_id,
  input  wire logic [spq_pkg::PRIO_BITS-1:0] front_priority,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [ID_BITS-1:0]   rid;
    logic [PRIO_BITS-1:0] rprio;
    logic [CNT_BITS-1:0]  count;
    logic                 fvalid;
    logic [ID_BITS-1:0]   fid;
    logic [PRIO_BITS-1:0] fprio;
  } rsp_word_t;

  // shadow copy of the cell row, front at index 0
  logic [ID_BITS-1:0]   list_id   [DEPTH];
  logic [PRIO_BITS-1:0] list_prio [DEPTH];
  int                   list_len;

  rsp_word_t expected_q[$];
  int        n_err;

  assign fail_count = n_err;

  // take out one entry and close the gap behind it
  task automatic drop_entry(input int pos);
    int i;
    for (i = pos; i + 1 < list_len; i = i + 1) begin
      list_id[i]   = list_id[i + 1];
      list_prio[i] = list_prio[i + 1];
    end
    list_len = list_len - 1;
  endtask

  // apply one request to the shadow list and build the response word it gives
  task automatic apply_request(input req_type_t op, input logic [ID_BITS-1:0] id,
                               input logic [PRIO_BITS-1:0] prio, output rsp_word_t w);
    int pos;
    int i;
    w = '0;
    w.status = ST_OK;
    case (op)
      REQ_INSERT: begin
        if (list_len >= DEPTH) begin
          w.status = ST_FULL;
        end else begin
          // behind every entry of equal or higher priority
          pos = 0;
          while (pos < list_len && list_prio[pos] >= prio) pos = pos + 1;
          for (i = list_len; i > pos; i = i - 1) begin
            list_id[i]   = list_id[i - 1];
            list_prio[i] = list_prio[i - 1];
          end
          list_id[pos]   = id;
          list_prio[pos] = prio;
          list_len       = list_len + 1;
        end
      end
      REQ_POP_FRONT: begin
        if (list_len == 0) begin
          w.status = ST_NOT_HERE;
        end else begin
          w.rid   = list_id[0];
          w.rprio = list_prio[0];
          drop_entry(0);
        end
      end
      default: begin
        // search and remove by id act on the match nearest the front
        pos = 0;
        while (pos < list_len && list_id[pos] != id) pos = pos + 1;
        if (pos >= list_len) begin
          w.status = ST_NOT_HERE;
        end else begin
          w.rid   = list_id[pos];
          w.rprio = list_prio[pos];
          if (op == REQ_REMOVE_ID) drop_entry(pos);
        end
      end
    endcase
    w.count = CNT_BITS'(list_len);
    if (list_len > 0) begin
      w.fvalid = 1'b1;
      w.fid    = list_id[0];
      w.fprio  = list_prio[0];
    end
  endtask

  // predict on each accepted request word, compare on each accepted response word
  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    if (rst) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (req_valid && req_ready) begin
        apply_request(req_type_t'(req_type), entry_id, entry_priority, want);
        expected_q.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        got.status = status_t'(status);
        got.rid    = result_id;
        got.rprio  = result_priority;
        got.count  = entry_count;
        got.fvalid = front_valid;
        got.fid    = front_id;
        got.fprio  = front_priority;
        if (expected_q.size() == 0) begin
          if (n_err < 10)
            $display("[%0t] unexpected response word: %p", $realtime, got);
          n_err = n_err + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.rid !== want.rid ||
              got.rprio !== want.rprio || got.count !== want.count ||
              got.fvalid !== want.fvalid || got.fid !== want.fid ||
              got.fprio !== want.fprio) begin
            if (n_err < 10) begin
              $display("[%0t] response mismatch", $realtime);
              $display("  expected: status %0d id %h prio %h count %0d front %b %h %h",
                       want.status, want.rid, want.rprio, want.count,
                       want.fvalid, want.fid, want.fprio);
              $display("  actual:   status %0d id %h prio %h count %0d front %b %h %h",
                       got.status, got.rid, got.rprio, got.count,
                       got.fvalid, got.fid, got.fprio);
            end
            n_err = n_err + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: clock, reset, request stimulus and response back-pressure for the sorted
// priority queue, with spq_checker beside it; depends on spq_pkg, spq_req_if, spq_rsp_if,
// spq_checker and sorted_priority_queue
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int N_RANDOM   = 1750;
  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   steady_phase;
  logic [ID_BITS-5:0] id_hi;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_type        (req.req_type),
    .entry_id        (req.entry_id),
    .entry_priority  (req.entry_priority),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .status          (rsp.status),
    .result_id       (rsp.result_id),
    .result_priority (rsp.result_priority),
    .entry_count     (rsp.entry_count),
    .front_valid     (rsp.front_valid),
    .front_id        (rsp.front_id),
    .front_priority  (rsp.front_priority),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ids mostly from a small pool so that searches hit, the rest anywhere
  function automatic logic [ID_BITS-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return {id_hi, 4'($urandom_range(0, 15))};
    if (r < 70) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return ID_BITS'($urandom_range(0, 65535));
  endfunction

  // priorities crowd on a few values to make ties
  function automatic logic [PRIO_BITS-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return PRIO_BITS'($urandom_range(0, 3));
    if (r < 45) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return PRIO_BITS'($urandom_range(0, 255));
  endfunction

  // response back-pressure
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      rsp.ready <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      rsp.ready <= 1'b0;
      hold = hold - 1;
    end else begin
      hold = steady_phase ? 0 : pick_gap();
      if (hold > 0) begin
        rsp.ready <= 1'b0;
        hold = hold - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // one request word, returns at the edge where it is taken
  task automatic send_word(input req_type_t op, input logic [ID_BITS-1:0] id,
                           input logic [PRIO_BITS-1:0] prio);
    int gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.req_type       <= op;
    req.entry_id       <= id;
    req.entry_priority <= prio;
    @(posedge clk);
    while (!(req.valid && req.ready)) @(posedge clk);
  endtask

  // hold off requests until every response word is back
  task automatic wait_all_done();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one random request; mix sets the share of inserts
  task automatic random_item(input int mix);
    int        r;
    int        ins_pct;
    req_type_t op;
    case (mix)
      0:       ins_pct = 75;
      1:       ins_pct = 20;
      2:       ins_pct = 45;
      default: ins_pct = 30;
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      op = REQ_INSERT;
    end else begin
      r = $urandom_range(0, 2);
      if (r == 0)      op = REQ_POP_FRONT;
      else if (r == 1) op = REQ_SEARCH;
      else             op = REQ_REMOVE_ID;
    end
    send_word(op, pick_id(), pick_prio());
  endtask

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle = idle + 1;
    end
    $display("** sorted_priority_queue: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int i;
    int sent;
    int len;
    int mix;
    int phase;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.req_type       = REQ_INSERT;
    req.entry_id       = '0;
    req.entry_priority = '0;
    steady_phase       = 1'b0;
    id_hi              = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty queue: nothing to remove or find
    send_word(REQ_POP_FRONT, 16'h0000, 8'h00);
    send_word(REQ_SEARCH, 16'hFFFF, 8'hFF);
    send_word(REQ_REMOVE_ID, 16'h1234, 8'h00);
    // extremes, ties at both ends and a duplicate id
    send_word(REQ_INSERT, 16'hFFFF, 8'hFF);
    send_word(REQ_INSERT, 16'h0000, 8'h00);
    send_word(REQ_INSERT, 16'h0001, 8'hFF);
    send_word(REQ_INSERT, 16'h0000, 8'h80);
    send_word(REQ_INSERT, 16'h0002, 8'h00);
    send_word(REQ_INSERT, 16'h0003, 8'h80);
    for (i = 0; i < 10; i = i + 1)
      send_word(REQ_INSERT, 16'(16'h0100 + i), 8'(i * 25));
    // full queue drops the insert
    send_word(REQ_INSERT, 16'hABCD, 8'h7F);
    // duplicate id hits the one nearest the front
    send_word(REQ_SEARCH, 16'h0000, 8'h00);
    send_word(REQ_SEARCH, 16'h5555, 8'h00);
    send_word(REQ_REMOVE_ID, 16'h0000, 8'h00);
    // removal of the next-to-last entry of the row
    send_word(REQ_REMOVE_ID, 16'h0002, 8'h00);
    send_word(REQ_POP_FRONT, 16'h0000, 8'h00);

    // random phases of fill, drain, balanced and lookup-heavy traffic
    sent  = 0;
    phase = 0;
    while (sent < N_RANDOM) begin
      len          = $urandom_range(40, 120);
      mix          = $urandom_range(0, 3);
      id_hi        = (ID_BITS - 4)'($urandom_range(0, 4095));
      if (phase == 0 || $urandom_range(0, 4) == 0) wait_all_done();
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        random_item(mix);
        sent = sent + 1;
      end
      phase = phase + 1;
    end

    steady_phase = 1'b0;
    wait_all_done();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
